### hw/rtl/cov_pkg.sv
// ============================================================================
// cov_pkg
// Shared types, constants and arithmetic step functions of the circle
// outline vertex generator.
// ============================================================================
`default_nettype none

package cov_pkg;

  localparam int unsigned CntW       = 13;
  localparam int unsigned StepW      = 12;
  localparam int unsigned CoordW     = 20;
  localparam int unsigned RadiusW    = 19;
  localparam int unsigned OutW       = 21;
  localparam int unsigned ProdW      = RadiusW + StepW;
  localparam int unsigned QuotW      = 20;
  localparam int unsigned RadW       = 2 * QuotW;
  localparam int unsigned RootW      = RadW / 2;
  localparam int unsigned SqRemW     = RootW + 1;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned DivStages  = QuotW / 2;
  localparam int unsigned SqrtStages = RootW / 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_RADIUS      = 3'd2,
    CFG_POINT_COUNT = 3'd3
  } cov_cfg_e;

  typedef struct packed {
    logic                    oor;
    logic [StepW-1:0]        slot_r;
    logic [CntW-1:0]         slot_l;
    logic signed [OutW-1:0]  y;
  } cov_side_t;

  typedef struct packed {
    logic [CntW-1:0] rem;
    logic            q;
  } cov_div_res_t;

  typedef struct packed {
    logic [SqRemW-1:0] rem;
    logic              q;
  } cov_sqrt_res_t;

  // one restoring division step
  function automatic cov_div_res_t div_step(logic [CntW-1:0] rem, logic nb,
                                            logic [CntW-1:0] d);
    logic [CntW:0] trial;
    cov_div_res_t  res;
    trial = {rem, nb};
    if (trial >= {1'b0, d}) begin
      res.rem = CntW'(trial - {1'b0, d});
      res.q   = 1'b1;
    end else begin
      res.rem = trial[CntW-1:0];
      res.q   = 1'b0;
    end
    return res;
  endfunction

  // one digit-by-digit square root step
  function automatic cov_sqrt_res_t sqrt_step(logic [SqRemW-1:0] rem, logic [1:0] pair,
                                              logic [RootW-1:0] root);
    logic [SqRemW+1:0] cur;
    logic [SqRemW+1:0] trial;
    cov_sqrt_res_t     res;
    cur   = {rem, pair};
    trial = {1'b0, root, 2'b01};
    if (cur >= trial) begin
      res.rem = SqRemW'(cur - trial);
      res.q   = 1'b1;
    end else begin
      res.rem = cur[SqRemW-1:0];
      res.q   = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cov_div.sv
// ============================================================================
// cov_div
// Pipelined restoring divider, two quotient bits per stage.
// ============================================================================
`default_nettype none

module cov_div import cov_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [ProdW-1:0] prod_i,
  input  wire logic [CntW-1:0]  divisor_i,
  output logic      [QuotW-1:0] quot_o
);

  logic [CntW-1:0]  rem_q [DivStages];
  logic [QuotW-1:0] low_q [DivStages];
  logic [QuotW-1:0] quo_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [CntW-1:0]  rem_in;
    logic [QuotW-1:0] low_in;
    logic [QuotW-1:0] quo_in;
    cov_div_res_t     st_a;
    cov_div_res_t     st_b;

    if (s == 0) begin : g_first
      // dividend is 4 * prod, quotient fits in QuotW bits
      assign rem_in = prod_i[ProdW-1 -: CntW];
      assign low_in = {prod_i[ProdW-CntW-1:0], 2'b00};
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      st_a = div_step(rem_in, low_in[QuotW-1], divisor_i);
      st_b = div_step(st_a.rem, low_in[QuotW-2], divisor_i);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= st_b.rem;
        low_q[s] <= {low_in[QuotW-3:0], 2'b00};
        quo_q[s] <= {quo_in[QuotW-3:0], st_a.q, st_b.q};
      end
    end
  end

  assign quot_o = quo_q[DivStages-1];

endmodule

`default_nettype wire

### hw/rtl/cov_sqrt.sv
// ============================================================================
// cov_sqrt
// Pipelined integer square root, two root bits per stage.
// ============================================================================
`default_nettype none

module cov_sqrt import cov_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [RadW-1:0] rad_i,
  output logic      [RootW-1:0] root_o
);

  logic [SqRemW-1:0] rem_q  [SqrtStages];
  logic [RadW-1:0]   low_q  [SqrtStages];
  logic [RootW-1:0]  root_q [SqrtStages];

  for (genvar s = 0; s < SqrtStages; s++) begin : g_stage
    logic [SqRemW-1:0] rem_in;
    logic [RadW-1:0]   low_in;
    logic [RootW-1:0]  root_in;
    logic [RootW-1:0]  root_mid;
    cov_sqrt_res_t     st_a;
    cov_sqrt_res_t     st_b;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign low_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign low_in  = low_q[s-1];
      assign root_in = root_q[s-1];
    end

    always_comb begin
      st_a     = sqrt_step(rem_in, low_in[RadW-1 -: 2], root_in);
      root_mid = {root_in[RootW-2:0], st_a.q};
      st_b     = sqrt_step(st_a.rem, low_in[RadW-3 -: 2], root_mid);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= st_b.rem;
        low_q[s]  <= {low_in[RadW-5:0], 4'b0000};
        root_q[s] <= {root_mid[RootW-2:0], st_b.q};
      end
    end
  end

  assign root_o = root_q[SqrtStages-1];

endmodule

`default_nettype wire

### hw/rtl/circle_outline_vertex_gen.sv
// ============================================================================
// circle_outline_vertex_gen
// Mirrored circle outline vertex pair per half-circle step index.
// ============================================================================
// Streams one step index per clock and returns the row y and the right and
// left x of that row, all signed fixed point with 4 fraction bits, together
// with the two vertex slots. The pipeline is one front stage with the
// radius by index product, ten divider stages for the row offset, one row
// stage, one radicand multiplier stage, ten square root stages and the output
// register. A new item enters every cycle; while a result is held by
// out_stall_i the whole pipeline holds and in_stall_o is high. Configuration
// writes are taken every cycle and must only happen while the pipeline is
// empty.
`default_nettype none

module circle_outline_vertex_gen import cov_pkg::*; #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [CoordW-1:0]      cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [StepW-1:0]       step_index_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [OutW-1:0]      point_y_o,
  output logic signed [OutW-1:0]      right_x_o,
  output logic signed [OutW-1:0]      left_x_o,
  output logic        [CntW-1:0]      right_slot_o,
  output logic        [CntW-1:0]      left_slot_o,
  output logic                        index_out_of_range_o
);

  localparam logic [16:0]  MaxPts = 17'(MAX_POINTS);
  localparam int unsigned  SRow   = 1 + DivStages;
  localparam int unsigned  SMul   = SRow + 1;
  localparam int unsigned  SOut   = SMul + 1 + SqrtStages;
  localparam int unsigned  NumStg = SOut + 1;

  logic [CoordW-1:0]  cx_q;
  logic [CoordW-1:0]  cy_q;
  logic [RadiusW-1:0] radius_q;
  logic [CntW-1:0]    cnt_q;

  logic [CntW-1:0]    cnt_sat;
  logic [CntW-1:0]    cnt_even;
  logic [CntW-1:0]    n_pts;

  logic               en;
  logic [NumStg-1:0]  vld_q;

  cov_side_t          side_in;
  cov_side_t          side_row;
  cov_side_t          side_q [SOut];
  logic [ProdW-1:0]   prod_d;
  logic [ProdW-1:0]   prod_q;

  logic [QuotW-1:0]   quot;
  logic signed [OutW-1:0] y_d;
  logic [QuotW-1:0]   off_q;
  logic [QuotW-1:0]   span_q;
  logic [RadW-1:0]    radicand_d;
  logic [RadW-1:0]    radicand_q;
  logic [RootW-1:0]   root;

  logic [OutW-1:0]    rx_d;
  logic [OutW-1:0]    lx_d;
  logic [OutW-1:0]    py_q;
  logic [OutW-1:0]    rx_q;
  logic [OutW-1:0]    lx_q;
  logic [CntW-1:0]    rslot_q;
  logic [CntW-1:0]    lslot_q;
  logic               oor_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      radius_q <= '0;
      cnt_q    <= CntW'(64);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CENTER_X:    cx_q     <= cfg_data_i;
        CFG_CENTER_Y:    cy_q     <= cfg_data_i;
        CFG_RADIUS:      radius_q <= cfg_data_i[RadiusW-1:0];
        CFG_POINT_COUNT: cnt_q    <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // effective even point count
  always_comb begin
    cnt_sat  = ({4'b0000, cnt_q} > MaxPts) ? MaxPts[CntW-1:0] : cnt_q;
    cnt_even = {cnt_sat[CntW-1:1], 1'b0};
    n_pts    = (cnt_even < CntW'(2)) ? CntW'(2) : cnt_even;
  end

  // pipeline control
  assign en          = !(vld_q[NumStg-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NumStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStg-2:0], in_valid_i};
    end
  end

  // front stage
  always_comb begin
    side_in.oor    = step_index_i > n_pts[CntW-1:1];
    side_in.slot_r = step_index_i;
    side_in.slot_l = n_pts - {1'b0, step_index_i};
    side_in.y      = '0;
    prod_d         = ProdW'({12'd0, radius_q} * {19'd0, step_index_i});
  end

  // side data entering the row stage picks up its y
  always_comb begin
    side_row   = side_q[SRow-1];
    side_row.y = y_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q    <= prod_d;
      side_q[0] <= side_in;
      for (int k = 1; k < SOut; k++) begin
        if (k == SRow) begin
          side_q[k] <= side_row;
        end else begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  cov_div u_div (
    .clk_i     (clk_i),
    .en_i      (en),
    .prod_i    (prod_q),
    .divisor_i (n_pts),
    .quot_o    (quot)
  );

  // row stage
  assign y_d = OutW'($signed({cy_q[CoordW-1], cy_q}) + $signed({1'b0, quot})
                     - $signed({2'b00, radius_q}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      off_q  <= quot;
      span_q <= {radius_q, 1'b0} - quot;
    end
  end

  // radicand r^2 - (y-cy)^2 as off * (2r - off)
  assign radicand_d = RadW'(off_q) * RadW'(span_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      radicand_q <= radicand_d;
    end
  end

  cov_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (radicand_q),
    .root_o (root)
  );

  // output stage
  assign rx_d = {cx_q[CoordW-1], cx_q} + {1'b0, root};
  assign lx_d = {cx_q[CoordW-1], cx_q} - {1'b0, root};

  always_ff @(posedge clk_i) begin
    if (en) begin
      oor_q <= side_q[SOut-1].oor;
      if (side_q[SOut-1].oor) begin
        py_q    <= '0;
        rx_q    <= '0;
        lx_q    <= '0;
        rslot_q <= '0;
        lslot_q <= '0;
      end else begin
        py_q    <= side_q[SOut-1].y;
        rx_q    <= rx_d;
        lx_q    <= lx_d;
        rslot_q <= {1'b0, side_q[SOut-1].slot_r};
        lslot_q <= side_q[SOut-1].slot_l;
      end
    end
  end

  assign point_y_o            = $signed(py_q);
  assign right_x_o            = $signed(rx_q);
  assign left_x_o             = $signed(lx_q);
  assign right_slot_o         = rslot_q;
  assign left_slot_o          = lslot_q;
  assign index_out_of_range_o = oor_q;

endmodule

`default_nettype wire

### hw/rtl/cov_chk.sv
// ============================================================================
// cov_chk
// Port-level checks of the circle outline vertex generator.
// ============================================================================
`default_nettype none

module cov_chk import cov_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   cfg_valid_i,
  input wire logic                   cfg_ready_o,
  input wire logic [CfgIdxW-1:0]     cfg_index_i,
  input wire logic [CoordW-1:0]      cfg_data_i,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic [StepW-1:0]       step_index_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic signed [OutW-1:0] point_y_o,
  input wire logic signed [OutW-1:0] right_x_o,
  input wire logic signed [OutW-1:0] left_x_o,
  input wire logic [CntW-1:0]        right_slot_o,
  input wire logic [CntW-1:0]        left_slot_o,
  input wire logic                   index_out_of_range_o
);

  // a held result holds the input side too
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input not stalled while result is held");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(left_x_o)
      && $stable(right_x_o) && $stable(point_y_o)))
    else $error("held result changed");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && index_out_of_range_o) |-> (point_y_o == '0 && right_x_o == '0
      && left_x_o == '0 && right_slot_o == '0 && left_slot_o == '0))
    else $error("out of range result not zero");

  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !index_out_of_range_o) |-> (right_x_o >= left_x_o))
    else $error("right point left of left point");

endmodule

bind circle_outline_vertex_gen cov_chk u_cov_chk (.*);

`default_nettype wire

### tb/circle_outline_vertex_gen_checker.sv
// ============================================================================
// circle_outline_vertex_gen_checker
// Tracks the register writes and the step stream of the circle outline
// vertex generator. For each accepted step index it computes the vertex
// pair from its own copy of the registers and queues it. Each accepted
// result is compared field by field against the oldest queued vertex pair.
// ============================================================================
`timescale 1ns / 100ps

module circle_outline_vertex_gen_checker import cov_pkg::*; #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CoordW-1:0]       cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [StepW-1:0]        step_index_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [OutW-1:0]  point_y_i,
  input  logic signed [OutW-1:0]  right_x_i,
  input  logic signed [OutW-1:0]  left_x_i,
  input  logic [CntW-1:0]         right_slot_i,
  input  logic [CntW-1:0]         left_slot_i,
  input  logic                    index_out_of_range_i,
  output int                      pending_o,
  output int                      fails_o,
  output int                      checked_o,
  output int                      oor_o
);

  localparam int ReportLimit = 10;

  typedef struct {
    logic [StepW-1:0]       step;
    logic signed [OutW-1:0] y;
    logic signed [OutW-1:0] rx;
    logic signed [OutW-1:0] lx;
    logic [CntW-1:0]        rslot;
    logic [CntW-1:0]        lslot;
    logic                   oor;
  } vertex_pair_t;

  logic [CoordW-1:0]  center_x_q;
  logic [CoordW-1:0]  center_y_q;
  logic [RadiusW-1:0] radius_q;
  logic [CntW-1:0]    count_q;
  vertex_pair_t       vertex_fifo[$];
  int                 fails = 0;
  int                 checked = 0;
  int                 oor_steps = 0;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  function automatic vertex_pair_t predict_vertex_pair(logic [StepW-1:0] step);
    vertex_pair_t    v;
    longint          n;
    longint          si;
    longint          cx;
    longint          cy;
    longint          r;
    longint          off;
    longint          dy;
    longint          rad;
    longint unsigned half_chord;
    v = '{default: '0};
    v.step = step;
    si = step;
    n = count_q;
    if (n > MAX_POINTS) n = MAX_POINTS;
    n = n - (n % 2);
    if (n < 2) n = 2;
    if (si > n / 2) begin
      v.oor = 1'b1;
      return v;
    end
    cx = $signed(center_x_q);
    cy = $signed(center_y_q);
    r = radius_q;
    off = (4 * r * si) / n;
    dy = off - r;
    rad = r * r - dy * dy;
    half_chord = (rad > 0) ? floor_root(rad) : 0;
    v.y = OutW'(cy + dy);
    v.rx = OutW'(cx + longint'(half_chord));
    v.lx = OutW'(cx - longint'(half_chord));
    v.rslot = CntW'(si);
    v.lslot = CntW'(n - si);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    vertex_pair_t want;
    if (!rst_ni) begin
      center_x_q = '0;
      center_y_q = '0;
      radius_q = '0;
      count_q = CntW'(64);
      vertex_fifo.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CENTER_X:    center_x_q = cfg_data_i;
          CFG_CENTER_Y:    center_y_q = cfg_data_i;
          CFG_RADIUS:      radius_q = cfg_data_i[RadiusW-1:0];
          CFG_POINT_COUNT: count_q = cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (vertex_fifo.size() == 0) begin
          fails++;
          if (fails <= ReportLimit) begin
            $display("%0t: result with no step pending: y=%0d rx=%0d lx=%0d", $realtime,
                     point_y_i, right_x_i, left_x_i);
          end
        end else begin
          want = vertex_fifo.pop_front();
          if (want.y !== point_y_i || want.rx !== right_x_i || want.lx !== left_x_i ||
              want.rslot !== right_slot_i || want.lslot !== left_slot_i ||
              want.oor !== index_out_of_range_i) begin
            fails++;
            if (fails <= ReportLimit) begin
              $display("%0t: step %0d expected y=%0d rx=%0d lx=%0d rs=%0d ls=%0d oor=%0b",
                       $realtime, want.step, want.y, want.rx, want.lx, want.rslot,
                       want.lslot, want.oor);
              $display("%0t: step %0d actual   y=%0d rx=%0d lx=%0d rs=%0d ls=%0d oor=%0b",
                       $realtime, want.step, point_y_i, right_x_i, left_x_i,
                       right_slot_i, left_slot_i, index_out_of_range_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = predict_vertex_pair(step_index_i);
        if (want.oor) oor_steps++;
        vertex_fifo.push_back(want);
      end
    end
    pending_o <= vertex_fifo.size();
    fails_o <= fails;
    checked_o <= checked;
    oor_o <= oor_steps;
  end

endmodule

### tb/tb_circle_outline_vertex_gen.sv
// ============================================================================
// tb_circle_outline_vertex_gen
// Stream test of the circle outline vertex generator.
// ============================================================================
// Programs center, radius and point count at their extremes and at random
// values, sends directed and random step indexes in and past the half circle
// with random gaps and output stalls, a long output hold and a full drain.
// A separate checker predicts and compares every vertex pair.
`timescale 1ns / 100ps

module tb_circle_outline_vertex_gen;
  import cov_pkg::*;

  localparam int unsigned MAX_POINTS = 4096;
  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles = 200;
  localparam int DrainCycles = 40;
  localparam int RandomPhases = 8;
  localparam int StepsPerPhase = 110;
  localparam logic [CfgIdxW-1:0] CfgSpareFirst = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSpareLast = 3'd7;
  localparam logic [CoordW-1:0] CoordMax = 20'h7FFFF;
  localparam logic [CoordW-1:0] CoordMin = 20'h80000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i;
  logic [CoordW-1:0]      cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [StepW-1:0]       step_index_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic signed [OutW-1:0] point_y_o;
  logic signed [OutW-1:0] right_x_o;
  logic signed [OutW-1:0] left_x_o;
  logic [CntW-1:0]        right_slot_o;
  logic [CntW-1:0]        left_slot_o;
  logic                   index_out_of_range_o;

  int pending;
  int fails;
  int checked;
  int oor_steps;
  int idle_cycles;
  int steps_sent = 0;
  int settings = 0;
  bit tx_idle;
  bit rx_idle;
  bit hold_req;
  logic [CntW-1:0] count_setting;

  circle_outline_vertex_gen #(
    .MAX_POINTS(MAX_POINTS)
  ) u_top (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .step_index_i,
    .out_valid_o,
    .out_stall_i,
    .point_y_o,
    .right_x_o,
    .left_x_o,
    .right_slot_o,
    .left_slot_o,
    .index_out_of_range_o
  );

  circle_outline_vertex_gen_checker #(
    .MAX_POINTS(MAX_POINTS)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_i(in_stall_o),
    .step_index_i,
    .out_valid_i(out_valid_o),
    .out_stall_i,
    .point_y_i(point_y_o),
    .right_x_i(right_x_o),
    .left_x_i(left_x_o),
    .right_slot_i(right_slot_o),
    .left_slot_i(left_slot_o),
    .index_out_of_range_i(index_out_of_range_o),
    .pending_o(pending),
    .fails_o(fails),
    .checked_o(checked),
    .oor_o(oor_steps)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // cycles without any transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WatchdogLimit);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int half_span(logic [CntW-1:0] pc);
    int n;
    n = pc;
    if (n > MAX_POINTS) n = MAX_POINTS;
    n = n - (n % 2);
    if (n < 2) n = 2;
    return n / 2;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoordW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy,
                              input logic [CoordW-1:0] r, input logic [CoordW-1:0] pc,
                              input bit spare);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_POINT_COUNT, pc);
    if (spare) begin
      write_reg(CfgIdxW'($urandom_range(CfgSpareFirst, CfgSpareLast)), CoordW'($urandom));
    end
    cfg_valid_i <= 1'b0;
    count_setting = pc[CntW-1:0];
    settings++;
  endtask

  task automatic send_step(input logic [StepW-1:0] idx);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    step_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    steps_sent++;
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic random_phase(input int p);
    int half;
    int pick;
    bit sweep;
    logic [StepW-1:0] idx;
    logic [CoordW-1:0] r;
    logic [CoordW-1:0] pc;
    case (p % 4)
      0: begin
        tx_idle = 1'b1;
        rx_idle = 1'b1;
      end
      1: begin
        tx_idle = 1'b0;
        rx_idle = 1'b1;
      end
      2: begin
        tx_idle = 1'b1;
        rx_idle = 1'b0;
      end
      default: begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
    endcase
    case ($urandom_range(0, 3))
      0: r = CoordW'($urandom_range(0, 64));
      1: r = CoordW'($urandom) | CoordMax;
      2: r = CoordW'($urandom_range(0, 4095));
      default: r = CoordW'($urandom);
    endcase
    pc = CoordW'($urandom);
    case ($urandom_range(0, 3))
      0: pc[CntW-1:0] = CntW'($urandom_range(0, 40));
      1: pc[CntW-1:0] = CntW'($urandom_range(4090, 8191));
      2: ;
      default: pc[CntW-1:0] = CntW'($urandom_range(41, 300));
    endcase
    program_regs(CoordW'($urandom), CoordW'($urandom), r, pc, bit'($urandom_range(0, 1)));
    half = half_span(count_setting);
    sweep = (half < StepsPerPhase) && ($urandom_range(0, 1) == 1);
    for (int k = 0; k < StepsPerPhase; k++) begin
      // output held long enough to back the pipeline up into the input
      if (p == 1 && k == 30) hold_req = 1'b1;
      if (p == 5 && k == 60) drain_all();
      pick = $urandom_range(0, 9);
      if (pick == 0) idx = StepW'($urandom);
      else if (sweep) idx = StepW'(k % (half + 1));
      else if (pick == 1) idx = StepW'(($urandom_range(0, 1) == 1) ? half : half + 1);
      else idx = StepW'($urandom_range(0, half));
      send_step(idx);
    end
    drain_all();
  endtask

  initial begin : receiver
    int hold;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req) begin
        hold = HoldCycles;
        hold_req = 1'b0;
      end else begin
        hold = rx_idle ? $urandom_range(0, 9) : 0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_CENTER_X;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    step_index_i = '0;
    out_stall_i = 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 1'b0;
    count_setting = CntW'(64);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero radius, 64 points
    send_step(StepW'(0));
    send_step(StepW'(32));
    send_step(StepW'(33));
    send_step(StepW'(4095));
    drain_all();

    // largest circle, count saturated to the maximum
    program_regs(CoordMax, CoordMin, 20'hFFFFF, 20'h01FFF, 1'b1);
    send_step(StepW'(0));
    send_step(StepW'(1));
    send_step(StepW'(1024));
    send_step(StepW'(1365));
    send_step(StepW'(2047));
    send_step(StepW'(2048));
    send_step(StepW'(2049));
    send_step(StepW'(2730));
    drain_all();

    // count of one treated as two
    program_regs(CoordMin, CoordMax, CoordMax, 20'd1, 1'b0);
    send_step(StepW'(0));
    send_step(StepW'(1));
    send_step(StepW'(2));
    drain_all();

    // count of zero
    program_regs(20'd0, 20'd0, 20'd1, 20'd0, 1'b0);
    send_step(StepW'(1));
    send_step(StepW'(2));
    drain_all();

    // odd count rounded down
    program_regs(20'd37, 20'hFFFC0, 20'd5, 20'd3, 1'b0);
    send_step(StepW'(0));
    send_step(StepW'(1));
    send_step(StepW'(2));
    drain_all();

    program_regs(20'd100, 20'hFFF9C, 20'd1000, 20'd4096, 1'b0);
    send_step(StepW'(2048));
    send_step(StepW'(2049));
    drain_all();

    for (int p = 0; p < RandomPhases; p++) random_phase(p);

    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d step indexes (%0d past the half circle) over %0d register settings",
             steps_sent, oor_steps, settings);
    $display("compared %0d vertex pairs, including a %0d cycle output hold",
             checked, HoldCycles);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cov_pkg.sv
hw/rtl/cov_div.sv
hw/rtl/cov_sqrt.sv
hw/rtl/circle_outline_vertex_gen.sv
hw/rtl/cov_chk.sv
tb/circle_outline_vertex_gen_checker.sv
tb/tb_circle_outline_vertex_gen.sv
